FILE: hdl/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds fixed-point widths, the CORDIC arctangent table and shared types.
// No dependencies.
`default_nettype none
package q2e_pkg;

  localparam int QuatFracBits = 14;
  localparam int CordicSteps  = 16;
  localparam int AtanEntries  = 24;

  // products and sums carry 2*QuatFracBits fraction bits
  localparam int Fb2     = 2 * QuatFracBits;
  localparam int SumW    = (Fb2 + 3 > 35) ? Fb2 + 3 : 35;
  localparam int CordicW = SumW + 3;
  localparam int AngW    = 28;

  // arcsine argument in units of 2^-30, its square root over a 62-bit radicand
  localparam int S30W    = 32;
  localparam int MagW    = 31;
  localparam int SqrtInW = 62;
  localparam int RootW   = SqrtInW / 2;
  localparam int RemW    = RootW + 2;

  localparam int Deg90    = 90 * 65536;
  localparam int AngleLim = 23040;
  localparam int PitchLim = 11520;

  typedef struct packed {
    logic signed [SumW-1:0] ra;
    logic signed [SumW-1:0] rb;
    logic signed [SumW-1:0] ya;
    logic signed [SumW-1:0] yb;
    logic signed [S30W-1:0] s30;
    logic                   clamped;
  } side_t;

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_deg16(input int idx);
    logic signed [AngW-1:0] r;
    case (idx)
      0:  r = AngW'(2949120);
      1:  r = AngW'(1740967);
      2:  r = AngW'(919879);
      3:  r = AngW'(466945);
      4:  r = AngW'(234379);
      5:  r = AngW'(117304);
      6:  r = AngW'(58666);
      7:  r = AngW'(29335);
      8:  r = AngW'(14668);
      9:  r = AngW'(7334);
      10: r = AngW'(3667);
      11: r = AngW'(1833);
      12: r = AngW'(917);
      13: r = AngW'(458);
      14: r = AngW'(229);
      15: r = AngW'(115);
      16: r = AngW'(57);
      17: r = AngW'(29);
      18: r = AngW'(14);
      19: r = AngW'(7);
      20: r = AngW'(4);
      21: r = AngW'(2);
      22: r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up to 1/128 degree, negate, saturate to +-lim
  function automatic logic signed [15:0] to_counts(input logic signed [AngW-1:0] a,
                                                   input int lim);
    logic signed [AngW-1:0] t;
    logic signed [AngW-1:0] l;
    logic signed [15:0]     r;
    l = AngW'(lim);
    t = (a + AngW'(256)) >>> 9;
    t = -t;
    if (t > l) begin
      r = 16'(lim);
    end else if (t < -l) begin
      r = -16'(lim);
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/q2e_front.sv
// Front end: quaternion products, ZYX sums, arcsine clamp and its square.
// Four register stages. Depends on q2e_pkg.
`default_nettype none
module q2e_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic signed [15:0]           w_i,
  input  wire logic signed [15:0]           x_i,
  input  wire logic signed [15:0]           y_i,
  input  wire logic signed [15:0]           z_i,
  output logic                              valid_o,
  output q2e_pkg::side_t                    side_o,
  output logic [q2e_pkg::SqrtInW-1:0]       rad_o
);
  import q2e_pkg::*;

  localparam int ShR = (Fb2 >= 30) ? Fb2 - 30 : 0;
  localparam int ShL = (Fb2 < 30) ? 30 - Fb2 : 0;

  logic [3:0] vld_q;

  // stage 1: products
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  // stage 2: sums
  logic signed [SumW-1:0] ra_q, rb_q, ya_q, yb_q, s_q;
  // stage 3: clamp and rescale
  side_t st3_q;
  // stage 4: square
  side_t st4_q;
  logic [2*MagW-1:0] sq_q;

  logic signed [SumW-1:0]    one_c;
  logic signed [SumW-1:0]    s_cl;
  logic                      cl_c;
  logic signed [SumW+31:0]   s_ext;
  logic signed [SumW+31:0]   s_sh;
  logic [S30W-1:0]           mag_c;

  always_comb begin
    one_c = SumW'(1) <<< Fb2;
    cl_c  = 1'b0;
    s_cl  = s_q;
    if (s_q > one_c) begin
      s_cl = one_c;
      cl_c = 1'b1;
    end else if (s_q < -one_c) begin
      s_cl = -one_c;
      cl_c = 1'b1;
    end
    s_ext = (SumW+32)'(s_cl);
    s_sh  = (Fb2 >= 30) ? (s_ext >>> ShR) : (s_ext <<< ShL);
    mag_c = st3_q.s30[S30W-1] ? -st3_q.s30 : st3_q.s30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= w_i * x_i;
      yz_q <= y_i * z_i;
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      wz_q <= w_i * z_i;
      xy_q <= x_i * y_i;
      zz_q <= z_i * z_i;
      wy_q <= w_i * y_i;
      zx_q <= z_i * x_i;

      ra_q <= (SumW'(wx_q) + SumW'(yz_q)) <<< 1;
      rb_q <= one_c - ((SumW'(xx_q) + SumW'(yy_q)) <<< 1);
      ya_q <= (SumW'(wz_q) + SumW'(xy_q)) <<< 1;
      yb_q <= one_c - ((SumW'(yy_q) + SumW'(zz_q)) <<< 1);
      s_q  <= (SumW'(wy_q) - SumW'(zx_q)) <<< 1;

      st3_q.ra      <= ra_q;
      st3_q.rb      <= rb_q;
      st3_q.ya      <= ya_q;
      st3_q.yb      <= yb_q;
      st3_q.s30     <= s_sh[S30W-1:0];
      st3_q.clamped <= cl_c;

      st4_q <= st3_q;
      sq_q  <= mag_c[MagW-1:0] * mag_c[MagW-1:0];
    end
  end

  assign valid_o = vld_q[3];
  assign side_o  = st4_q;
  assign rad_o   = (SqrtInW'(1) << 60) - SqrtInW'(sq_q);

endmodule
`default_nettype wire

FILE: hdl/q2e_isqrt.sv
// Pipelined integer square root, one result bit per stage, side data alongside.
// Depends on q2e_pkg.
`default_nettype none
module q2e_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire q2e_pkg::side_t              side_i,
  input  wire logic [q2e_pkg::SqrtInW-1:0] rad_i,
  output logic                             valid_o,
  output q2e_pkg::side_t                   side_o,
  output logic [q2e_pkg::RootW-1:0]        root_o
);
  import q2e_pkg::*;

  logic [RootW-1:0]   vld_q;
  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [SqrtInW-1:0] rad_q  [RootW];
  side_t              side_q [RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]    cur_rem;
    logic [RootW-1:0]   cur_root;
    logic [SqrtInW-1:0] cur_rad;
    side_t              cur_side;
    logic [RemW-1:0]    rem_pre;
    logic [RemW-1:0]    trial;

    if (k == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = rad_i;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur_rem  = rem_q[k-1];
      assign cur_root = root_q[k-1];
      assign cur_rad  = rad_q[k-1];
      assign cur_side = side_q[k-1];
    end

    assign rem_pre = {cur_rem[RemW-3:0], cur_rad[SqrtInW-1 -: 2]};
    assign trial   = {cur_root, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= cur_rad << 2;
        side_q[k] <= cur_side;
        if (rem_pre >= trial) begin
          rem_q[k]  <= rem_pre - trial;
          root_q[k] <= {cur_root[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_pre;
          root_q[k] <= {cur_root[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign side_o  = side_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule
`default_nettype wire

FILE: hdl/q2e_cordic.sv
// Vectoring CORDIC for atan2(y, x), one rotation per stage after a quadrant fold.
// Angle out in units of 2^-16 degree. Depends on q2e_pkg.
`default_nettype none
module q2e_cordic (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [q2e_pkg::CordicW-1:0] y_i,
  input  wire logic signed [q2e_pkg::CordicW-1:0] x_i,
  output logic                                    valid_o,
  output logic signed [q2e_pkg::AngW-1:0]         angle_o
);
  import q2e_pkg::*;

  localparam int NStg = CordicSteps + 1;

  logic [NStg-1:0]            vld_q;
  logic signed [CordicW-1:0]  x_q [NStg];
  logic signed [CordicW-1:0]  y_q [NStg];
  logic signed [AngW-1:0]     z_q [NStg];
  logic [NStg-1:0]            zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], valid_i};
    end
  end

  // fold the left half-plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= AngW'(Deg90);
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -AngW'(Deg90);
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    localparam logic signed [AngW-1:0] Atan = atan_deg16(i);
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - Atan;
        end
      end
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign angle_o = zero_q[NStg-1] ? '0 : z_q[NStg-1];

endmodule
`default_nettype wire

FILE: hdl/quaternion_to_euler_angles.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_isqrt and q2e_cordic.
//
//  channel  dir  tdata fields (low bit first)
//  s_axis   in   quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
//  m_axis   out  roll_angle[15:0] pitch_angle[30:16] yaw_angle[46:31] pitch_clamped[47]
//
//  One quaternion per cycle unless stalled; data passes q2e_front, the one-bit-per-stage
//  square root (31), the 16-step CORDIC with its fold stage and the output register.
//  Reset clears only the stage valid bits and the output valid.
//  The whole pipeline advances when the output register is empty or taken;
//  a stall freezes every stage in place.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // roll_angle, pitch_angle, yaw_angle, pitch_clamped
);
  import q2e_pkg::*;

  logic                      en;
  logic                      fe_vld, sq_vld, r_vld, p_vld, y_vld;
  side_t                     fe_side, sq_side;
  logic [SqrtInW-1:0]        fe_rad;
  logic [RootW-1:0]          root;
  logic signed [AngW-1:0]    r_ang, p_ang, y_ang;
  logic [CordicSteps:0]      clamp_q;
  logic                      out_vld_q;
  logic signed [15:0]        roll_q, yaw_q, pitch_w;
  logic signed [14:0]        pitch_q;
  logic                      clamped_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  q2e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .w_i     (s_axis_tdata[15:0]),
    .x_i     (s_axis_tdata[31:16]),
    .y_i     (s_axis_tdata[47:32]),
    .z_i     (s_axis_tdata[63:48]),
    .valid_o (fe_vld),
    .side_o  (fe_side),
    .rad_o   (fe_rad)
  );

  q2e_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_vld),
    .side_i  (fe_side),
    .rad_i   (fe_rad),
    .valid_o (sq_vld),
    .side_o  (sq_side),
    .root_o  (root)
  );

  q2e_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (CordicW'(sq_side.ra)),
    .x_i     (CordicW'(sq_side.rb)),
    .valid_o (r_vld),
    .angle_o (r_ang)
  );

  q2e_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (CordicW'(sq_side.s30)),
    .x_i     (CordicW'({1'b0, root})),
    .valid_o (p_vld),
    .angle_o (p_ang)
  );

  q2e_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (CordicW'(sq_side.ya)),
    .x_i     (CordicW'(sq_side.yb)),
    .valid_o (y_vld),
    .angle_o (y_ang)
  );

  // carry the clamp flag alongside the CORDIC stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      clamp_q <= {clamp_q[CordicSteps-1:0], sq_side.clamped};
    end
  end

  assign pitch_w = to_counts(p_ang, PitchLim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q    <= to_counts(r_ang, AngleLim);
      pitch_q   <= pitch_w[14:0];
      yaw_q     <= to_counts(y_ang, AngleLim);
      clamped_q <= clamp_q[CordicSteps];
    end
  end

  // roll and yaw run in lockstep with pitch; their valids match it
  logic unused_vld;
  assign unused_vld = r_vld ^ y_vld;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {clamped_q, yaw_q, pitch_q, roll_q}
                         | {47'd0, unused_vld & 1'b0};

endmodule
`default_nettype wire

FILE: hdl/q2e_checker.sv
// Port-level checks for the quaternion to Euler angle converter, bound to the top.
// Depends on quaternion_to_euler_angles.
`default_nettype none
module q2e_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with free output");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd11520)
                   && ($signed(m_axis_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles q2e_assert u_q2e_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: verif/q2e_checker.sv
// Checker for the quaternion to Euler angle converter: watches both stream channels,
// predicts each conversion with a CORDIC angle model and compares field by field.
// Depends on q2e_pkg for the arctangent table.
`timescale 1ns / 100ps
module q2e_checker (
  input  wire logic        clk_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [63:0] s_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [47:0] m_tdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  import q2e_pkg::*;

  localparam longint Deg90L = 64'sd90 * 65536;

  logic [47:0] angle_queue[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd1 << 31;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // vectoring CORDIC; result in 2^-16 degree
  function automatic longint cordic_angle(longint yv, longint xv);
    longint acc, tmp, dx, dy;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      tmp = xv;
      if (yv >= 0) begin
        xv = yv; yv = -tmp; acc = Deg90L;
      end else begin
        xv = -yv; yv = tmp; acc = -Deg90L;
      end
    end
    for (int i = 0; i < CordicSteps && i < AtanEntries; i++) begin
      dx = floor_shift(yv, i);
      dy = floor_shift(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; acc += longint'(atan_deg16(i));
      end else begin
        xv -= dx; yv += dy; acc -= longint'(atan_deg16(i));
      end
    end
    return acc;
  endfunction

  function automatic longint deg_counts(longint a, longint lim);
    longint r;
    r = -floor_shift(a + 256, 9);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [47:0] euler_of(logic [63:0] q);
    longint w, x, y, z, one, ra, rb, ya, yb, s, s30, c, roll, pitch, yaw;
    logic clamp;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    one = 64'sd1 <<< Fb2;
    ra = 2 * (w * x + y * z);
    rb = one - 2 * (x * x + y * y);
    ya = 2 * (w * z + x * y);
    yb = one - 2 * (y * y + z * z);
    s = 2 * (w * y - z * x);
    clamp = 1'b0;
    if (s > one) begin s = one; clamp = 1'b1; end
    if (s < -one) begin s = -one; clamp = 1'b1; end
    if (Fb2 >= 30) s30 = floor_shift(s, Fb2 - 30);
    else s30 = s * (64'sd1 <<< (30 - Fb2));
    c = root_floor((64'sd1 <<< 60) - s30 * s30);
    roll = deg_counts(cordic_angle(ra, rb), AngleLim);
    pitch = deg_counts(cordic_angle(s30, c), PitchLim);
    yaw = deg_counts(cordic_angle(ya, yb), AngleLim);
    return {clamp, yaw[15:0], pitch[14:0], roll[15:0]};
  endfunction

  initial fail_count_o = 0;
  assign pending_o = angle_queue.size();

  always @(posedge clk_i) begin
    logic [47:0] want;
    if (s_tvalid_i && s_tready_i) angle_queue.push_back(euler_of(s_tdata_i));
    if (m_tvalid_i && m_tready_i) begin
      if (angle_queue.size() == 0) begin
        $error("unexpected transfer %h", m_tdata_i);
        fail_count_o++;
      end else begin
        want = angle_queue.pop_front();
        if (want[15:0] !== m_tdata_i[15:0]) begin
          $error("roll_angle exp %0d got %0d", $signed(want[15:0]), $signed(m_tdata_i[15:0]));
          fail_count_o++;
        end
        if (want[30:16] !== m_tdata_i[30:16]) begin
          $error("pitch_angle exp %0d got %0d", $signed(want[30:16]),
                 $signed(m_tdata_i[30:16]));
          fail_count_o++;
        end
        if (want[46:31] !== m_tdata_i[46:31]) begin
          $error("yaw_angle exp %0d got %0d", $signed(want[46:31]), $signed(m_tdata_i[46:31]));
          fail_count_o++;
        end
        if (want[47] !== m_tdata_i[47]) begin
          $error("pitch_clamped exp %0d got %0d", want[47], m_tdata_i[47]);
          fail_count_o++;
        end
      end
    end
  end
endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for the quaternion to Euler angle converter.
// Depends on quaternion_to_euler_angles and q2e_checker.
`timescale 1ns / 100ps
module testbench;
  localparam int RandItems = 1530;
  localparam int Latency   = 53;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // roll_angle, pitch_angle, yaw_angle, pitch_clamped
  int          fail_count, pending, cycle_count = 0;
  bit          hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_angles dut (.*);

  q2e_checker u_checker (
    .clk_i, .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("quaternion_to_euler_angles test failed");
      $finish;
    end
  end

  // receiver: random stall pattern, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (cycle_count % 400 < 150) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    hold_off = 1'b0;
    wait (cycle_count == 700);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return 16'h8000 + 16'($urandom_range(0, 3));
      1: return 16'h7FFF - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // unit quaternion from a random direction, scaled to about 1.0
  function automatic logic [63:0] rand_unit();
    real a, b, c, d, n;
    a = $itor($signed(16'($urandom)));
    b = $itor($signed(16'($urandom)));
    c = $itor($signed(16'($urandom)));
    d = $itor($signed(16'($urandom)));
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
            16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
  endfunction

  task automatic send_quat(logic [63:0] q);
    s_axis_tdata <= q;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  initial begin
    int burst;
    logic [63:0] directed[$];
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // identity, zero vector, extremes, pure rotations, clamped arcsine
    directed = '{64'h0000_0000_0000_4000, 64'h0, 64'h8000_8000_8000_8000,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h0000_0000_4000_0000,
                 64'h0000_4000_0000_0000, 64'h4000_0000_0000_0000,
                 64'h0000_2D41_0000_2D41, 64'h0000_D2BF_0000_2D41,
                 64'h0000_7FFF_0000_7FFF, 64'h0000_8000_0000_7FFF,
                 64'h2D41_0000_0000_2D41, 64'h0000_0000_2D41_2D41,
                 64'h8000_0000_7FFF_0000, 64'h0000_0000_0000_C000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h0001_0001_0001_0001,
                 64'h7FFF_8000_7FFF_8000, 64'h0000_0000_C000_0000,
                 64'h2000_2000_2000_2000};
    foreach (directed[i]) send_quat(directed[i]);
    for (int n = 0; n < RandItems; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < RandItems; k++, n++) begin
        if ($urandom_range(0, 9) < 6) send_quat(rand_unit());
        else send_quat({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) $display("quaternion_to_euler_angles test passed");
    else $display("quaternion_to_euler_angles test failed");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_isqrt.sv
hdl/q2e_cordic.sv
hdl/quaternion_to_euler_angles.sv
hdl/q2e_checker.sv
verif/q2e_checker.sv
verif/testbench.sv
